// ===== sv/gtsh_pkg.sv =====
// constants and types for the gas transmitter scaler with probe-loss hysteresis
// no dependencies; imported by the core, the checker and the testbench
package gtsh_pkg;

  localparam int ReadingW = 15;
  localparam int PpmW     = 15;
  localparam int StatusW  = 2;
  localparam int AddrW    = 4;
  localparam int DataW    = 32;

  // current loop thresholds in microamps
  localparam logic [ReadingW-1:0] CUR_NOPROBE_UA = ReadingW'(2000);
  localparam logic [ReadingW-1:0] CUR_ZERO_UA    = ReadingW'(4000);

  // voltage thresholds in millivolts
  localparam logic [ReadingW-1:0] VOLT_LOSS_MV    = ReadingW'(300);
  localparam logic [ReadingW-1:0] VOLT_RECOVER_MV = ReadingW'(400);

  // probe status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK           = 2'd0,
    ST_NO_PROBE     = 2'd1,
    ST_NOT_ASSIGNED = 2'd2,
    ST_NOT_ENABLED  = 2'd3
  } status_t;

  // register indexes, byte address is 4 * index
  typedef enum logic [1:0] {
    REG_PROBE_ENABLE   = 2'd0,
    REG_PROBE_ASSIGNED = 2'd1,
    REG_RANGE_SELECT   = 2'd2,
    REG_SIGNAL_MODE    = 2'd3
  } reg_idx_t;

endpackage

// ===== sv/gas_transmitter_scaler_hysteresis_core.sv =====
// gas transmitter scaler: 4-20 mA / 0-10 V reading to ppm with probe-loss hysteresis
// depends on gtsh_pkg
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid / in_stall    | reading
//  out     | output    | out_valid / out_stall  | concentration_ppm, probe_status
//  cfg     | input     | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// one word per cycle sustained while out_stall stays low; an input register then a result register
// the scaling is shift-and-add on constant ratios, so one short path feeds the result
// register; the probe-loss flag updates as a word moves into the result register
// a held result stalls the input register, which in turn raises in_stall
// synchronous active-high reset clears valids, the config registers and the flag
module gas_transmitter_scaler_hysteresis_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gtsh_pkg::AddrW-1:0]       paddr,
  input  logic [gtsh_pkg::DataW-1:0]       pwdata,
  output logic [gtsh_pkg::DataW-1:0]       prdata,
  output logic                             pready,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gtsh_pkg::ReadingW-1:0]    reading,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gtsh_pkg::PpmW-1:0]        concentration_ppm,
  output logic [gtsh_pkg::StatusW-1:0]     probe_status
);
  import gtsh_pkg::*;

  logic                probe_enable;
  logic                probe_assigned;
  logic                range_select;
  logic                signal_mode;
  logic                lost_probe_flag;
  logic                lost_probe_flag_next;

  logic                in_vld;
  logic [ReadingW-1:0] in_reading;
  logic                res_load;
  logic                in_load;

  logic [ReadingW-1:0] delta;
  logic [ReadingW+2:0] delta_x5;
  logic [PpmW-1:0]     ppm_cur;
  logic [PpmW-1:0]     ppm_volt;
  logic [PpmW-1:0]     ppm_next;
  status_t             status_next;
  reg_idx_t            wr_idx;
  reg_idx_t            rd_idx;

  assign pready = 1'b1;
  assign wr_idx = reg_idx_t'(paddr[3:2]);
  assign rd_idx = reg_idx_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_enable   <= 1'b0;
      probe_assigned <= 1'b0;
      range_select   <= 1'b0;
      signal_mode    <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (wr_idx)
        REG_PROBE_ENABLE:   probe_enable   <= pwdata[0];
        REG_PROBE_ASSIGNED: probe_assigned <= pwdata[0];
        REG_RANGE_SELECT:   range_select   <= pwdata[0];
        REG_SIGNAL_MODE:    signal_mode    <= pwdata[0];
        default:            ;
      endcase
    end
  end

  // register reads
  always_comb begin
    prdata = '0;
    case (rd_idx)
      REG_PROBE_ENABLE:   prdata[0] = probe_enable;
      REG_PROBE_ASSIGNED: prdata[0] = probe_assigned;
      REG_RANGE_SELECT:   prdata[0] = range_select;
      REG_SIGNAL_MODE:    prdata[0] = signal_mode;
      default:            prdata = '0;
    endcase
  end

  // pipeline flow control
  assign res_load = in_vld && (!out_valid || !out_stall);
  assign in_stall = in_vld && !res_load;
  assign in_load  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_load) begin
      in_vld <= 1'b1;
    end else if (res_load) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_reading <= reading;
    end
  end

  // scaling: current is (r-4000)*5/16 or *5/8, voltage is r/2 or r
  assign delta    = in_reading - CUR_ZERO_UA;
  assign delta_x5 = {1'b0, delta, 2'b00} + {3'b000, delta};
  assign ppm_cur  = range_select ? delta_x5[ReadingW+2:3]
                                 : {1'b0, delta_x5[ReadingW+2:4]};
  assign ppm_volt = range_select ? in_reading : {1'b0, in_reading[ReadingW-1:1]};

  // status, ppm and hysteresis flag
  always_comb begin
    ppm_next             = '0;
    status_next          = ST_OK;
    lost_probe_flag_next = lost_probe_flag;
    if (!probe_enable) begin
      status_next = ST_NOT_ENABLED;
    end else if (!probe_assigned) begin
      status_next = ST_NOT_ASSIGNED;
    end else if (!signal_mode) begin
      status_next = (in_reading <= CUR_NOPROBE_UA) ? ST_NO_PROBE : ST_OK;
      if (in_reading > CUR_ZERO_UA) begin
        ppm_next = ppm_cur;
      end
    end else if (in_reading < VOLT_LOSS_MV) begin
      lost_probe_flag_next = 1'b1;
      status_next          = ST_NO_PROBE;
    end else if (lost_probe_flag) begin
      if (in_reading > VOLT_RECOVER_MV) begin
        lost_probe_flag_next = 1'b0;
        status_next          = ST_OK;
      end else begin
        status_next = ST_NO_PROBE;
      end
    end else begin
      ppm_next = ppm_volt;
    end
  end

  // result register and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      lost_probe_flag <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid       <= 1'b1;
        lost_probe_flag <= lost_probe_flag_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      concentration_ppm <= ppm_next;
      probe_status      <= status_next;
    end
  end

endmodule

// ===== test/gas_transmitter_scaler_hysteresis_core_checker.sv =====
// checker for the gas transmitter scaler: watches the register port and both word channels
// predicts each result word and compares it field by field; depends on gtsh_pkg
`timescale 1ns / 100ps
module gas_transmitter_scaler_hysteresis_core_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gtsh_pkg::AddrW-1:0]    paddr,
  input  logic [gtsh_pkg::DataW-1:0]    pwdata,
  input  logic [gtsh_pkg::DataW-1:0]    prdata,
  input  logic                          pready,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [gtsh_pkg::ReadingW-1:0] reading,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [gtsh_pkg::PpmW-1:0]     concentration_ppm,
  input  logic [gtsh_pkg::StatusW-1:0]  probe_status,
  output int                            mismatches,
  output int                            words_pending,
  output int                            words_checked
);
  import gtsh_pkg::*;

  localparam int unsigned FS_LOW_PPM   = 5000;
  localparam int unsigned FS_HIGH_PPM  = 10000;
  localparam int unsigned CUR_SPAN_UA  = 16000;
  localparam int unsigned VOLT_SPAN_MV = 10000;
  localparam int          REPORT_LIMIT = 10;

  typedef struct packed {
    logic [PpmW-1:0] ppm;
    status_t         status;
  } scaled_t;

  scaled_t expected_words[$];

  // shadow registers and the probe-loss flag
  logic enable_r;
  logic assigned_r;
  logic range_r;
  logic mode_r;
  logic lost_probe;

  // ppm and status for one reading; updates the probe-loss flag in voltage mode
  function automatic scaled_t scale_reading(input logic [ReadingW-1:0] r);
    scaled_t     res;
    int unsigned full_scale;
    full_scale = range_r ? FS_HIGH_PPM : FS_LOW_PPM;
    res.ppm    = '0;
    res.status = ST_OK;
    if (!enable_r) begin
      res.status = ST_NOT_ENABLED;
    end else if (!assigned_r) begin
      res.status = ST_NOT_ASSIGNED;
    end else if (!mode_r) begin
      // current loop: 4..20 mA onto 0..full scale
      if (r <= CUR_NOPROBE_UA) res.status = ST_NO_PROBE;
      if (r > CUR_ZERO_UA)
        res.ppm = PpmW'((32'(r) - 32'(CUR_ZERO_UA)) * full_scale / CUR_SPAN_UA);
    end else if (r < VOLT_LOSS_MV) begin
      lost_probe = 1'b1;
      res.status = ST_NO_PROBE;
    end else if (lost_probe) begin
      // recovery word reports zero with ok status
      if (r > VOLT_RECOVER_MV) lost_probe = 1'b0;
      else res.status = ST_NO_PROBE;
    end else begin
      res.ppm = PpmW'(32'(r) * full_scale / VOLT_SPAN_MV);
    end
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want_v,
                               input int unsigned got_v);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("mismatch at %0t: %s expected %0d got %0d", $time, what, want_v, got_v);
  endtask

  always @(posedge clk) begin
    scaled_t want;
    logic    want_bit;
    if (rst) begin
      expected_words.delete();
      enable_r   = 1'b0;
      assigned_r = 1'b0;
      range_r    = 1'b0;
      mode_r     = 1'b0;
      lost_probe = 1'b0;
    end else begin
      // register writes and readback
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[AddrW-1:2]))
            REG_PROBE_ENABLE:   enable_r   = pwdata[0];
            REG_PROBE_ASSIGNED: assigned_r = pwdata[0];
            REG_RANGE_SELECT:   range_r    = pwdata[0];
            REG_SIGNAL_MODE:    mode_r     = pwdata[0];
            default:            ;
          endcase
        end else begin
          case (reg_idx_t'(paddr[AddrW-1:2]))
            REG_PROBE_ENABLE:   want_bit = enable_r;
            REG_PROBE_ASSIGNED: want_bit = assigned_r;
            REG_RANGE_SELECT:   want_bit = range_r;
            default:            want_bit = mode_r;
          endcase
          if (prdata !== DataW'(want_bit))
            note_mismatch("register readback", 32'(want_bit), prdata);
        end
      end
      // accepted input word
      if (in_valid && !in_stall) expected_words.push_back(scale_reading(reading));
      // accepted result word
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          note_mismatch("result word with none outstanding, ppm", 0,
                        32'(concentration_ppm));
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (concentration_ppm !== want.ppm)
            note_mismatch("concentration_ppm", 32'(want.ppm), 32'(concentration_ppm));
          if (probe_status !== want.status)
            note_mismatch("probe_status", 32'(want.status), 32'(probe_status));
        end
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

// ===== test/gas_transmitter_scaler_hysteresis_core_tb.sv =====
// testbench top for the gas transmitter scaler: clock, reset, register setup and readings
// depends on gtsh_pkg, gas_transmitter_scaler_hysteresis_core and the checker module
`timescale 1ns / 100ps
module gas_transmitter_scaler_hysteresis_core_tb;
  import gtsh_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 12;
  localparam int WORDS_PER_PHASE = 62;
  localparam int DRAIN_CYCLES    = 8;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [AddrW-1:0]    paddr     = '0;
  logic [DataW-1:0]    pwdata    = '0;
  logic                in_valid  = 1'b0;
  logic [ReadingW-1:0] reading   = '0;
  logic                out_stall = 1'b0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_stall;
  logic                out_valid;
  logic [PpmW-1:0]     concentration_ppm;
  logic [StatusW-1:0]  probe_status;

  int mismatches;
  int words_pending;
  int words_checked;
  int idle_pct         = 34;
  int readings_sent    = 0;
  int settings_applied = 0;
  int cycle_count      = 0;

  gas_transmitter_scaler_hysteresis_core u_dut (.*);

  gas_transmitter_scaler_hysteresis_core_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // random backpressure on the result channel
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d words outstanding",
               cycle_count, words_pending);
      $display("simulation failed");
      $finish;
    end
  end

  // one reading word, with random idle cycles ahead of it
  task automatic send_reading(input logic [ReadingW-1:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    reading  <= value;
    do @(posedge clk); while (in_stall);
    readings_sent++;
  endtask

  // wait until every outstanding result word has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  // setup phase and access phase, then back to idle
  task automatic reg_access(input reg_idx_t idx, input logic write, input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= DataW'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write all four registers once the block is idle, then read them back
  task automatic apply_setting(input logic en, input logic asg, input logic rng,
                               input logic mode);
    wait_idle();
    reg_access(REG_PROBE_ENABLE, 1'b1, en);
    reg_access(REG_PROBE_ASSIGNED, 1'b1, asg);
    reg_access(REG_RANGE_SELECT, 1'b1, rng);
    reg_access(REG_SIGNAL_MODE, 1'b1, mode);
    reg_access(REG_PROBE_ENABLE, 1'b0, 1'b0);
    reg_access(REG_PROBE_ASSIGNED, 1'b0, 1'b0);
    reg_access(REG_RANGE_SELECT, 1'b0, 1'b0);
    reg_access(REG_SIGNAL_MODE, 1'b0, 1'b0);
    settings_applied++;
  endtask

  initial begin
    logic [ReadingW-1:0] value;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // current loop, 5000 ppm: no-probe and zero thresholds, top of the field
    apply_setting(1'b1, 1'b1, 1'b0, 1'b0);
    send_reading(15'd0);
    send_reading(15'd2000);
    send_reading(15'd2001);
    send_reading(15'd4000);
    send_reading(15'd4001);
    send_reading(15'd20000);
    send_reading(15'd24000);
    send_reading(15'd32767);

    // current loop, 10000 ppm
    apply_setting(1'b1, 1'b1, 1'b1, 1'b0);
    send_reading(15'd20000);
    send_reading(15'd32767);

    // voltage, 10000 ppm: probe loss, hold band, recovery word, then scaling again
    apply_setting(1'b1, 1'b1, 1'b1, 1'b1);
    send_reading(15'd10000);
    send_reading(15'd300);
    send_reading(15'd299);
    send_reading(15'd300);
    send_reading(15'd400);
    send_reading(15'd401);
    send_reading(15'd401);
    send_reading(15'd0);

    // disabled and unassigned probes leave the loss flag alone
    apply_setting(1'b0, 1'b1, 1'b1, 1'b1);
    send_reading(15'd24000);
    apply_setting(1'b1, 1'b0, 1'b1, 1'b1);
    send_reading(15'd24000);
    apply_setting(1'b1, 1'b1, 1'b0, 1'b1);
    send_reading(15'd350);
    send_reading(15'd32767);
    send_reading(15'd32767);

    // random readings, weighted toward the thresholds of both modes
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      idle_pct = (phase == 6 || phase == 7) ? 0 : 34;
      apply_setting(phase != 5, phase != 9, phase[1], phase[0]);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        case ($urandom_range(9))
          0, 1:    value = ReadingW'($urandom_range(600));
          2:       value = ReadingW'($urandom_range(4200, 1800));
          3:       value = ReadingW'($urandom_range(32767));
          default: value = ReadingW'($urandom_range(24000));
        endcase
        send_reading(value);
      end
    end

    // drain and settle
    idle_pct = 34;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d readings sent under %0d register settings, %0d result words compared",
             readings_sent, settings_applied, words_checked);
    $display("both signal modes and full scales, probe-loss hysteresis, disabled and unassigned");
    if (mismatches == 0 && words_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/gtsh_pkg.sv
sv/gas_transmitter_scaler_hysteresis_core.sv
test/gas_transmitter_scaler_hysteresis_core_checker.sv
test/gas_transmitter_scaler_hysteresis_core_tb.sv
